>>> hdl/pps_pkg.sv
// Shared types and constants for the blob pool stepper.
package pps_pkg;
    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_ADD  = 32'd1013904223;
    localparam logic [31:0] SEED_XOR = 32'hBADBA110;
    localparam logic signed [19:0] POS_MAX = 20'sd524287;
    localparam logic signed [19:0] POS_MIN = -20'sd524288;
    localparam logic signed [19:0] SPAWN_NEAR = -20'sd3277;
    localparam logic signed [19:0] SPAWN_FAR = 20'sd68813;
    localparam logic signed [19:0] POS_RESET = 20'sd32768;

    localparam logic [2:0] REG_CAP   = 3'd0;
    localparam logic [2:0] REG_DENS  = 3'd1;
    localparam logic [2:0] REG_SPEED = 3'd2;
    localparam logic [2:0] REG_SJIT  = 3'd3;
    localparam logic [2:0] REG_DRIFT = 3'd4;
    localparam logic [2:0] REG_SIZE  = 3'd5;
    localparam logic [2:0] REG_EDGE  = 3'd6;
    localparam logic [2:0] REG_SEED  = 3'd7;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_LEFT   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] vel_x;
        logic signed [19:0] vel_y;
        logic [15:0]        radius;
    } t_blob;

    function automatic logic signed [19:0] sat20(input logic signed [37:0] v);
        if (v > 38'(POS_MAX)) return POS_MAX;
        if (v < 38'(POS_MIN)) return POS_MIN;
        return v[19:0];
    endfunction
endpackage

>>> hdl/pps_mul.sv
// Shared signed multiplier with registered product.
module pps_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

>>> hdl/particle_pool_step.sv
// Blob pool stepper top level: slot store, sequencer and shared multiplier.
//   channel | dir | handshake         | words
//   tick    | in  | i_valid / o_stall | tick_dt
//   report  | out | o_valid / i_stall | one word per slot below cap
//   config  | in  | i_cfg_we          | register write, no wait
// A tick runs acceptance, then MOVE, MX, MY and CULL per live slot moved, MOVE
// alone per dead slot, a scan step per live slot skipped or to close the respawn
// scan, the draws of each respawn (plus an edge draw if random) and the report.
// Input is stalled from acceptance until the last report word is taken.
// Reset is synchronous; slot state resets through flip-flops at once.
module particle_pool_step #(
    parameter int POOL_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_tick_dt,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_slot,
    output logic               o_alive,
    output logic signed [19:0] o_pos_x,
    output logic signed [19:0] o_pos_y,
    output logic signed [19:0] o_vel_x,
    output logic signed [19:0] o_vel_y,
    output logic [15:0]        o_radius,
    output logic [5:0]         o_live_count,
    output logic               o_last_slot
);
    import pps_pkg::*;

    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOVE  = 4'd1;
    localparam logic [3:0] S_MX    = 4'd2;
    localparam logic [3:0] S_MY    = 4'd3;
    localparam logic [3:0] S_CULL  = 4'd4;
    localparam logic [3:0] S_SPAWN = 4'd5;
    localparam logic [3:0] S_RNG   = 4'd6;
    localparam logic [3:0] S_DRAW  = 4'd7;
    localparam logic [3:0] S_JMUL  = 4'd8;
    localparam logic [3:0] S_JFIN  = 4'd9;
    localparam logic [3:0] S_JF2   = 4'd10;
    localparam logic [3:0] S_PLACE = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [5:0]  r_cap_reg;
    logic [8:0]  r_dens;
    logic [17:0] r_speed;
    logic [16:0] r_sjit;
    logic signed [17:0] r_drift_base;
    logic [14:0] r_size;
    logic [2:0]  r_edge_mode;
    logic [31:0] r_rng;

    logic [POOL_SLOTS-1:0] r_alive;
    t_blob r_blob [POOL_SLOTS];

    logic [3:0]  r_st;
    logic [IW-1:0] r_i;
    logic [CW-1:0] r_cap;
    logic [CW-1:0] r_target;
    logic [CW-1:0] r_live;
    logic [15:0] r_dt;
    t_blob       r_cur;
    logic [2:0]  r_draw;
    logic [1:0]  r_edge;
    logic [15:0] r_along;
    logic signed [25:0] r_s;
    logic signed [41:0] r_fac;
    logic signed [19:0] r_spd;
    logic signed [19:0] r_dft;
    logic        r_valid;

    logic signed [32:0] w_a, w_b;
    logic signed [65:0] w_p;

    pps_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_p));

    logic [CW-1:0] w_cap;
    logic [8:0]    w_dens;
    logic [16:0]   w_sj;
    logic [17:0]   w_tgt;
    always_comb begin
        if (r_cap_reg == 6'd0) w_cap = CW'(1);
        else if (32'(r_cap_reg) > POOL_SLOTS) w_cap = CW'(POOL_SLOTS);
        else w_cap = CW'(r_cap_reg);
        w_dens = (r_dens > 9'd256) ? 9'd256 : r_dens;
        w_sj = (r_sjit > 17'd65536) ? 17'd65536 : r_sjit;
        w_tgt = (18'(w_dens) * 18'(w_cap) + 18'd128) >> 8;
    end

    // rounding half away from zero of p / 2^16
    logic signed [49:0] w_mag, w_rnd;
    logic signed [37:0] w_step;
    always_comb begin
        w_mag = w_p[65] ? -w_p[49:0] : w_p[49:0];
        w_rnd = (w_mag + 50'sd32768) >>> 16;
        w_step = w_p[65] ? -w_rnd[37:0] : w_rnd[37:0];
    end

    logic signed [20:0] w_margin;
    assign w_margin = 21'(r_cur.radius) + 21'sd32768;

    logic signed [19:0] w_move;
    assign w_move = (r_st == S_MX) ? r_cur.pos_x : r_cur.pos_y;

    // draw: rng * MUL done in the multiplier, ADD added to its product
    logic [31:0] w_rng_n;
    logic [23:0] w_u;
    assign w_rng_n = w_p[31:0] + LCG_ADD;
    assign w_u = w_rng_n[31:8];

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_st)
            S_MOVE: begin
                w_a = 33'(r_cur.vel_x);
                w_b = 33'($signed({1'b0, r_dt}));
            end
            S_MX: begin
                w_a = 33'(r_cur.vel_y);
                w_b = 33'($signed({1'b0, r_dt}));
            end
            S_RNG: begin
                w_a = $signed({1'b0, r_rng});
                w_b = $signed({1'b0, LCG_MUL});
            end
            S_JMUL: begin
                w_a = 33'(r_s);
                case (r_draw)
                    3'd2: w_b = 33'($signed({1'b0, w_sj}));
                    3'd3: w_b = 33'sd6554;
                    default: w_b = 33'sd19661;
                endcase
            end
            S_JF2: begin
                w_a = 33'(r_fac[41:16]);
                w_b = (r_draw == 3'd2) ? 33'($signed({1'b0, r_speed}))
                                       : 33'($signed({1'b0, r_size}));
            end
            default: ;
        endcase
    end

    // low 16 bits of factor times base, added to the high-part product
    logic signed [60:0] w_lo;
    always_comb begin
        if (r_draw == 3'd2) w_lo = 61'($signed({1'b0, r_fac[15:0]})) * 61'(r_speed);
        else w_lo = 61'($signed({1'b0, r_fac[15:0]})) * 61'(r_size);
    end

    logic signed [66:0] w_tot;
    assign w_tot = (67'(w_p) <<< 16) + 67'(w_lo) + (67'sd1 <<< 39);

    logic [15:0] w_size;
    assign w_size = ((w_tot >>> 40) < 67'sd7) ? 16'd7 : 16'(w_tot >>> 40);

    logic [4:0] w_slot_out;
    assign w_slot_out = 5'(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_reg <= 6'd8;
            r_dens <= 9'd102;
            r_speed <= 18'd45875;
            r_sjit <= 17'd32768;
            r_drift_base <= '0;
            r_size <= 15'd7864;
            r_edge_mode <= 3'd0;
            r_rng <= 32'd535552 ^ SEED_XOR;
            r_alive <= '0;
            r_st <= S_IDLE;
            r_valid <= 1'b0;
            r_i <= '0;
            r_live <= '0;
            for (int k = 0; k < POOL_SLOTS; k++) begin
                r_blob[k] <= '{POS_RESET, POS_RESET, 20'sd0, 20'sd0, 16'd0};
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CAP:   r_cap_reg <= i_cfg_data[5:0];
                    REG_DENS:  r_dens <= i_cfg_data[8:0];
                    REG_SPEED: r_speed <= i_cfg_data[17:0];
                    REG_SJIT:  r_sjit <= i_cfg_data[16:0];
                    REG_DRIFT: r_drift_base <= i_cfg_data[17:0];
                    REG_SIZE:  r_size <= i_cfg_data[14:0];
                    REG_EDGE:  r_edge_mode <= i_cfg_data[2:0];
                    REG_SEED:  r_rng <= {1'b0, i_cfg_data} ^ SEED_XOR;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dt <= i_tick_dt;
                        r_cap <= w_cap;
                        r_target <= CW'(w_tgt);
                        r_live <= '0;
                        r_i <= '0;
                        r_cur <= r_blob[0];
                        r_st <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    if (!r_alive[r_i]) begin
                        if (32'(r_i) + 1 >= 32'(r_cap)) begin
                            r_i <= '0;
                            r_cur <= r_blob[0];
                            r_st <= S_SPAWN;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_cur <= r_blob[r_i + 1'b1];
                        end
                    end else begin
                        r_st <= S_MX;
                    end
                end
                S_MX: begin
                    r_cur.pos_x <= sat20(38'(w_move) + w_step);
                    r_st <= S_MY;
                end
                S_MY: begin
                    r_cur.pos_y <= sat20(38'(w_move) + w_step);
                    r_st <= S_CULL;
                end
                S_CULL: begin
                    r_blob[r_i] <= r_cur;
                    if (21'(r_cur.pos_x) < -w_margin
                        || 21'(r_cur.pos_x) > 21'sd65536 + w_margin
                        || 21'(r_cur.pos_y) < -w_margin
                        || 21'(r_cur.pos_y) > 21'sd65536 + w_margin) begin
                        r_alive[r_i] <= 1'b0;
                    end else begin
                        r_live <= r_live + 1'b1;
                    end
                    if (32'(r_i) + 1 >= 32'(r_cap)) begin
                        r_i <= '0;
                        r_st <= S_SPAWN;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_cur <= r_blob[r_i + 1'b1];
                        r_st <= S_MOVE;
                    end
                end
                S_SPAWN: begin
                    for (int k = 0; k < POOL_SLOTS; k++) begin
                        if (k >= 32'(r_cap)) r_alive[k] <= 1'b0;
                    end
                    if (r_live >= r_target) begin
                        r_i <= '0;
                        r_st <= S_OUT;
                        r_valid <= 1'b1;
                    end else if (r_alive[r_i]) begin
                        if (32'(r_i) + 1 >= 32'(r_cap)) begin
                            r_i <= '0;
                            r_st <= S_OUT;
                            r_valid <= 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_draw <= (r_edge_mode >= 3'd4) ? 3'd0 : 3'd1;
                        r_edge <= r_edge_mode[1:0];
                        r_st <= S_RNG;
                    end
                end
                S_RNG: r_st <= S_DRAW;
                S_DRAW: begin
                    r_rng <= w_rng_n;
                    r_s <= $signed({1'b0, w_u, 1'b0}) - 26'sd16777216;
                    case (r_draw)
                        3'd0: begin
                            r_edge <= w_u[23:22];
                            r_draw <= 3'd1;
                            r_st <= S_RNG;
                        end
                        3'd1: begin
                            r_along <= w_u[23:8];
                            r_draw <= 3'd2;
                            r_st <= S_RNG;
                        end
                        default: r_st <= S_JMUL;
                    endcase
                end
                S_JMUL: r_st <= S_JFIN;
                S_JFIN: begin
                    if (r_draw == 3'd3) begin
                        r_dft <= sat20(38'(r_drift_base) + 38'(
                            w_p[65] ? -((-w_p + 66'sd8388608) >>> 24)
                                    : ((w_p + 66'sd8388608) >>> 24)));
                        r_draw <= 3'd4;
                        r_st <= S_RNG;
                    end else begin
                        r_fac <= (42'sd1 <<< 40) + 42'(w_p);
                        r_st <= S_JF2;
                    end
                end
                S_JF2: r_st <= S_PLACE;
                S_PLACE: begin
                    if (r_draw == 3'd2) begin
                        r_spd <= 20'(w_tot >>> 40);
                        r_draw <= 3'd3;
                        r_st <= S_RNG;
                    end else begin
                        r_alive[r_i] <= 1'b1;
                        r_live <= r_live + 1'b1;
                        case (r_edge)
                            SIDE_TOP: r_blob[r_i] <= '{20'(r_along), SPAWN_NEAR,
                                r_dft, r_spd, w_size};
                            SIDE_BOTTOM: r_blob[r_i] <= '{20'(r_along), SPAWN_FAR,
                                r_dft, -r_spd, w_size};
                            SIDE_LEFT: r_blob[r_i] <= '{SPAWN_NEAR, 20'(r_along),
                                r_spd, r_dft, w_size};
                            default: r_blob[r_i] <= '{SPAWN_FAR, 20'(r_along),
                                -r_spd, r_dft, w_size};
                        endcase
                        if (32'(r_i) + 1 >= 32'(r_cap)) begin
                            r_i <= '0;
                            r_st <= S_OUT;
                            r_valid <= 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_st <= S_SPAWN;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (32'(r_i) + 1 >= 32'(r_cap)) begin
                            r_valid <= 1'b0;
                            r_st <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    t_blob w_ob;
    assign w_ob = r_blob[r_i];
    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_valid;
    assign o_slot = w_slot_out;
    assign o_alive = r_alive[r_i];
    assign o_pos_x = w_ob.pos_x;
    assign o_pos_y = w_ob.pos_y;
    assign o_vel_x = w_ob.vel_x;
    assign o_vel_y = w_ob.vel_y;
    assign o_radius = w_ob.radius;
    assign o_live_count = 6'(r_live);
    assign o_last_slot = (32'(r_i) + 1 == 32'(r_cap));

`ifndef SYNTHESIS
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_st == S_OUT)) else $error("valid outside report");
    a_live_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_live <= r_cap)) else $error("live above cap");
    a_idx_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(r_i) < 32'(r_cap))) else $error("slot beyond cap");
`endif
endmodule
